// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("implication check failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(label, clk, rst_n, cond, expr)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== src/cigar_pkg.sv =====
// Types, codes and decode functions for the CIGAR string parser.
package cigar_pkg;

  // Operation type codes as carried in seg_kind.
  localparam logic [2:0] OP_M  = 3'd0;
  localparam logic [2:0] OP_I  = 3'd1;
  localparam logic [2:0] OP_D  = 3'd2;
  localparam logic [2:0] OP_N  = 3'd3;
  localparam logic [2:0] OP_S  = 3'd4;
  localparam logic [2:0] OP_H  = 3'd5;
  localparam logic [2:0] OP_EQ = 3'd6;
  localparam logic [2:0] OP_X  = 3'd7;

  // Decoded letter classes beyond the eight real operations.
  localparam logic [3:0] CODE_PAD = 4'd8;
  localparam logic [3:0] CODE_BAD = 4'd9;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DIGIT = 2'd1;
  localparam logic [1:0] ST_BAD_CODE = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_terminator;
  } in_item_t;

  typedef struct packed {
    logic        segment_valid;
    logic [2:0]  seg_kind;
    logic [31:0] seg_length;
    logic        is_last;
    logic [1:0]  status;
    logic [31:0] read_total;
    logic [31:0] ref_total;
  } out_item_t;

  // Map an ASCII letter to its operation code.
  function automatic logic [3:0] code_of(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      8'h4D:   r = {1'b0, OP_M};
      8'h49:   r = {1'b0, OP_I};
      8'h44:   r = {1'b0, OP_D};
      8'h4E:   r = {1'b0, OP_N};
      8'h53:   r = {1'b0, OP_S};
      8'h48:   r = {1'b0, OP_H};
      8'h3D:   r = {1'b0, OP_EQ};
      8'h58:   r = {1'b0, OP_X};
      8'h50:   r = CODE_PAD;
      default: r = CODE_BAD;
    endcase
    return r;
  endfunction

  // Operations that consume read bases.
  function automatic logic counts_read(input logic [2:0] t);
    return (t == OP_M) || (t == OP_I) || (t == OP_S) || (t == OP_EQ) || (t == OP_X);
  endfunction

  // Operations that consume reference bases.
  function automatic logic counts_ref(input logic [2:0] t);
    return (t == OP_M) || (t == OP_D) || (t == OP_N) || (t == OP_EQ) || (t == OP_X);
  endfunction

endpackage

// ===== src/cigar_string_parser_unit.sv =====
// CIGAR string parser: one character beat in, merged segments and totals out.
// Each accepted beat is held in the input register; any result it makes is then registered in the result register.
// Throughput: one character per cycle; the input register and result register
// advance together whenever the result register is empty or being drained.
// Reset: rst_ni asynchronously clears the valid flags and all parse state.
`include "assert_macros.svh"
module cigar_string_parser_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cigar_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cigar_pkg::out_item_t out_item_o
);
  import cigar_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam int WD = LENGTH_BITS + 4;

  // Input register
  logic     in_vld_q, in_vld_d;
  in_item_t in_q;

  // Result register
  logic      out_vld_q, out_vld_d;
  out_item_t out_q, out_d;

  // Parse state
  logic [LB-1:0] acc_q, acc_d;
  logic          have_q, have_d;
  logic          pv_q, pv_d;
  logic [2:0]    ptype_q, ptype_d;
  logic [LB-1:0] plen_q, plen_d;
  logic          disc_q, disc_d;
  logic [LB-1:0] rsum_q, rsum_d;
  logic [LB-1:0] fsum_q, fsum_d;

  logic      out_free, go, accept, emit;
  out_item_t res;
  logic      is_digit;
  logic [WD-1:0] dval;
  logic      dovf;
  logic [3:0] code;
  logic [2:0] t;
  logic [LB:0] rd_new, rf_new, merge_len;

  // Handshake: the input stage moves on whenever the result register can load
  assign out_free    = !out_vld_q || !out_stall_i;
  assign go          = in_vld_q && out_free;
  assign in_stall_o  = in_vld_q && !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Datapath pieces: decimal shift-add, code decode, the three sums
  assign is_digit = (in_q.char_byte >= 8'h30) && (in_q.char_byte <= 8'h39);
  assign dval = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
              + WD'(in_q.char_byte[3:0]);
  assign dovf = |dval[WD-1:LB];
  assign code = code_of(in_q.char_byte);
  assign t    = code[2:0];
  assign rd_new    = {1'b0, rsum_q} + (counts_read(t) ? {1'b0, acc_q} : '0);
  assign rf_new    = {1'b0, fsum_q} + (counts_ref(t) ? {1'b0, acc_q} : '0);
  assign merge_len = {1'b0, plen_q} + {1'b0, acc_q};

  // Parse one character and decide the result
  always_comb begin
    acc_d   = acc_q;
    have_d  = have_q;
    pv_d    = pv_q;
    ptype_d = ptype_q;
    plen_d  = plen_q;
    disc_d  = disc_q;
    rsum_d  = rsum_q;
    fsum_d  = fsum_q;
    emit    = 1'b0;
    res     = '0;
    if (in_q.is_terminator) begin
      if (!disc_q) begin
        emit        = 1'b1;
        res.is_last = 1'b1;
        if (have_q) begin
          res.status = ST_BAD_CODE;
        end else begin
          res.status     = ST_OK;
          res.read_total = 32'(rsum_q);
          res.ref_total  = 32'(fsum_q);
          if (pv_q) begin
            res.segment_valid = 1'b1;
            res.seg_kind      = ptype_q;
            res.seg_length    = 32'(plen_q);
          end
        end
      end
      acc_d = '0; have_d = 1'b0; pv_d = 1'b0; ptype_d = '0;
      plen_d = '0; disc_d = 1'b0; rsum_d = '0; fsum_d = '0;
    end else if (!disc_q) begin
      if (is_digit) begin
        if (dovf) begin
          emit = 1'b1; res.status = ST_OVERFLOW;
        end else begin
          acc_d  = dval[LB-1:0];
          have_d = 1'b1;
        end
      end else if (!have_q) begin
        emit = 1'b1; res.status = ST_NO_DIGIT;
      end else if (code == CODE_BAD) begin
        emit = 1'b1; res.status = ST_BAD_CODE;
      end else begin
        acc_d  = '0;
        have_d = 1'b0;
        if (code != CODE_PAD && acc_q != '0) begin
          if (rd_new[LB] || rf_new[LB]) begin
            emit = 1'b1; res.status = ST_OVERFLOW;
          end else if (pv_q && ptype_q == t) begin
            if (merge_len[LB]) begin
              emit = 1'b1; res.status = ST_OVERFLOW;
            end else begin
              plen_d = merge_len[LB-1:0];
              rsum_d = rd_new[LB-1:0];
              fsum_d = rf_new[LB-1:0];
            end
          end else begin
            rsum_d = rd_new[LB-1:0];
            fsum_d = rf_new[LB-1:0];
            if (pv_q) begin
              emit              = 1'b1;
              res.segment_valid = 1'b1;
              res.seg_kind      = ptype_q;
              res.seg_length    = 32'(plen_q);
            end
            pv_d    = 1'b1;
            ptype_d = t;
            plen_d  = acc_q;
          end
        end
      end
      // Error: drop everything and skip to the terminator
      if (emit && res.status != ST_OK) begin
        res.is_last = 1'b1;
        acc_d = '0; have_d = 1'b0; pv_d = 1'b0; ptype_d = '0;
        plen_d = '0; rsum_d = '0; fsum_d = '0;
        disc_d = 1'b1;
      end
    end
  end

  // Next values of the pipeline valids and result
  always_comb begin
    in_vld_d  = accept ? 1'b1 : (go ? 1'b0 : in_vld_q);
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (go && emit) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Control and parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
      have_q    <= 1'b0;
      pv_q      <= 1'b0;
      ptype_q   <= '0;
      plen_q    <= '0;
      disc_q    <= 1'b0;
      rsum_q    <= '0;
      fsum_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (go) begin
        acc_q   <= acc_d;
        have_q  <= have_d;
        pv_q    <= pv_d;
        ptype_q <= ptype_d;
        plen_q  <= plen_d;
        disc_q  <= disc_d;
        rsum_q  <= rsum_d;
        fsum_q  <= fsum_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
    out_q <= out_d;
  end

  // Error results close the string and carry no segment
  `ASSERT_IMPL(a_err_is_last, clk_i, rst_ni, out_vld_q && out_q.status != ST_OK, out_q.is_last && !out_q.segment_valid)
  // A result that is not last is always a flushed segment
  `ASSERT_IMPL(a_mid_has_seg, clk_i, rst_ni, out_vld_q && !out_q.is_last, out_q.segment_valid && out_q.status == ST_OK)
  // While skipping to the terminator no digits or segment are held
  `ASSERT_NEVER(a_disc_clean, clk_i, rst_ni, disc_q && (have_q || pv_q))

endmodule
